// ----- design/tlw_pkg.sv -----
`timescale 1ns / 1ps
// types, codes and microcode control word for the two-level page table walker
// no dependencies; used by tlw_ucode_rom, the core and tlw_checker
package tlw_pkg;

  localparam int unsigned EntryIdxW = 10;
  localparam int unsigned StepW     = 5;

  // entry flag bits
  localparam int unsigned EntPresent = 0;
  localparam int unsigned EntWrite   = 1;
  localparam int unsigned EntUser    = 2;

  // configuration register byte addresses
  localparam int unsigned PaddrW = 3;
  localparam logic [PaddrW-1:0] RegDirectoryFrame = 3'd0;

  typedef enum logic [1:0] {
    ACT_MAP   = 2'd0,
    ACT_UNMAP = 2'd1,
    ACT_XLATE = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] virtual_address;
    logic [31:0] physical_address;
    logic [11:0] page_flags;
    logic [7:0]  spare_table_frame;
  } in_item_t;

  typedef struct packed {
    logic [31:0] physical_result;
    logic        mapped;
    logic        table_created;
  } out_item_t;

  typedef logic [StepW-1:0] step_t;

  // microcode step addresses
  localparam step_t ST_CLRALL      = 5'd0;
  localparam step_t ST_IDLE        = 5'd1;
  localparam step_t ST_PREP_SPARE  = 5'd2;
  localparam step_t ST_LD_DIRF     = 5'd3;
  localparam step_t ST_RD_DIR      = 5'd4;
  localparam step_t ST_LD_DENT     = 5'd5;
  localparam step_t ST_WAIT_TF     = 5'd6;
  localparam step_t ST_DISP_MAP    = 5'd7;
  localparam step_t ST_DISP_UNMAP  = 5'd8;
  localparam step_t ST_DISP_XLATE  = 5'd9;
  localparam step_t ST_DISP_NONE   = 5'd10;
  localparam step_t ST_MAP_CHK     = 5'd11;
  localparam step_t ST_MAP_CLR     = 5'd12;
  localparam step_t ST_MAP_DIR     = 5'd13;
  localparam step_t ST_MAP_PRES    = 5'd14;
  localparam step_t ST_MAP_SETU    = 5'd15;
  localparam step_t ST_MAP_ENT     = 5'd16;
  localparam step_t ST_UN_CHK      = 5'd17;
  localparam step_t ST_UN_CLR      = 5'd18;
  localparam step_t ST_XL_CHK      = 5'd19;
  localparam step_t ST_XL_RD       = 5'd20;
  localparam step_t ST_XL_RES      = 5'd21;
  localparam step_t ST_DONE_WAIT   = 5'd22;
  localparam step_t ST_DONE_OUT    = 5'd23;

  typedef enum logic [3:0] {
    C_NEVER        = 4'd0,
    C_ALWAYS       = 4'd1,
    C_NO_ACCEPT    = 4'd2,
    C_CNT_MORE     = 4'd3,
    C_TBL_MORE     = 4'd4,
    C_IS_MAP       = 4'd5,
    C_IS_UNMAP     = 4'd6,
    C_IS_XLATE     = 4'd7,
    C_DENT_PRESENT = 4'd8,
    C_DENT_ABSENT  = 4'd9,
    C_NO_USER_NEED = 4'd10,
    C_OUT_BUSY     = 4'd11
  } cond_e;

  typedef enum logic [1:0] {
    A_ALL    = 2'd0,
    A_TBLCLR = 2'd1,
    A_DIR    = 2'd2,
    A_TAB    = 2'd3
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_ZERO   = 2'd0,
    WD_NEWDIR = 2'd1,
    WD_DIRU   = 2'd2,
    WD_ENTRY  = 2'd3
  } wd_sel_e;

  typedef enum logic [1:0] {
    MS_CFG   = 2'd0,
    MS_SPARE = 2'd1,
    MS_RDATA = 2'd2
  } mod_src_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_INC  = 2'd2
  } cnt_op_e;

  typedef enum logic [1:0] {
    TF_HOLD = 2'd0,
    TF_MOD  = 2'd1,
    TF_NF   = 2'd2
  } tf_sel_e;

  typedef struct packed {
    cond_e     cond;
    step_t     target;
    logic      mem_we;
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    mod_src_e  mod_src;
    cnt_op_e   cnt_op;
    tf_sel_e   tf_sel;
    logic      ld_dirf;
    logic      ld_nf;
    logic      ld_dent;
    logic      ld_created;
    logic      ld_result;
    logic      clr_res;
    logic      out_load;
    logic      in_ready;
  } ctl_t;

endpackage

// ----- design/tlw_ucode_rom.sv -----
`timescale 1ns / 1ps
// microcode store: one control word per sequencer step
// depends on tlw_pkg
module tlw_ucode_rom (
  input  tlw_pkg::step_t step_i,
  output tlw_pkg::ctl_t  ctl_o
);

  always_comb begin
    ctl_o = '0;
    unique case (step_i)
      tlw_pkg::ST_CLRALL: begin
        ctl_o.mem_we   = 1'b1;
        ctl_o.addr_sel = tlw_pkg::A_ALL;
        ctl_o.wd_sel   = tlw_pkg::WD_ZERO;
        ctl_o.cnt_op   = tlw_pkg::CNT_INC;
        ctl_o.cond     = tlw_pkg::C_CNT_MORE;
        ctl_o.target   = tlw_pkg::ST_CLRALL;
      end
      tlw_pkg::ST_IDLE: begin
        ctl_o.in_ready = 1'b1;
        ctl_o.mod_src  = tlw_pkg::MS_CFG;
        ctl_o.cnt_op   = tlw_pkg::CNT_CLR;
        ctl_o.clr_res  = 1'b1;
        ctl_o.cond     = tlw_pkg::C_NO_ACCEPT;
        ctl_o.target   = tlw_pkg::ST_IDLE;
      end
      tlw_pkg::ST_PREP_SPARE: begin
        ctl_o.mod_src = tlw_pkg::MS_SPARE;
      end
      tlw_pkg::ST_LD_DIRF: begin
        ctl_o.ld_dirf = 1'b1;
      end
      tlw_pkg::ST_RD_DIR: begin
        ctl_o.addr_sel = tlw_pkg::A_DIR;
        ctl_o.ld_nf    = 1'b1;
      end
      tlw_pkg::ST_LD_DENT: begin
        ctl_o.ld_dent = 1'b1;
        ctl_o.mod_src = tlw_pkg::MS_RDATA;
      end
      tlw_pkg::ST_WAIT_TF: begin
        ctl_o.cond = tlw_pkg::C_NEVER;
      end
      tlw_pkg::ST_DISP_MAP: begin
        ctl_o.tf_sel = tlw_pkg::TF_MOD;
        ctl_o.cond   = tlw_pkg::C_IS_MAP;
        ctl_o.target = tlw_pkg::ST_MAP_CHK;
      end
      tlw_pkg::ST_DISP_UNMAP: begin
        ctl_o.cond   = tlw_pkg::C_IS_UNMAP;
        ctl_o.target = tlw_pkg::ST_UN_CHK;
      end
      tlw_pkg::ST_DISP_XLATE: begin
        ctl_o.cond   = tlw_pkg::C_IS_XLATE;
        ctl_o.target = tlw_pkg::ST_XL_CHK;
      end
      tlw_pkg::ST_DISP_NONE: begin
        ctl_o.cond   = tlw_pkg::C_ALWAYS;
        ctl_o.target = tlw_pkg::ST_DONE_WAIT;
      end
      tlw_pkg::ST_MAP_CHK: begin
        ctl_o.cond   = tlw_pkg::C_DENT_PRESENT;
        ctl_o.target = tlw_pkg::ST_MAP_PRES;
      end
      tlw_pkg::ST_MAP_CLR: begin
        ctl_o.mem_we   = 1'b1;
        ctl_o.addr_sel = tlw_pkg::A_TBLCLR;
        ctl_o.wd_sel   = tlw_pkg::WD_ZERO;
        ctl_o.cnt_op   = tlw_pkg::CNT_INC;
        ctl_o.cond     = tlw_pkg::C_TBL_MORE;
        ctl_o.target   = tlw_pkg::ST_MAP_CLR;
      end
      tlw_pkg::ST_MAP_DIR: begin
        ctl_o.mem_we     = 1'b1;
        ctl_o.addr_sel   = tlw_pkg::A_DIR;
        ctl_o.wd_sel     = tlw_pkg::WD_NEWDIR;
        ctl_o.tf_sel     = tlw_pkg::TF_NF;
        ctl_o.ld_created = 1'b1;
        ctl_o.cond       = tlw_pkg::C_ALWAYS;
        ctl_o.target     = tlw_pkg::ST_MAP_ENT;
      end
      tlw_pkg::ST_MAP_PRES: begin
        ctl_o.cond   = tlw_pkg::C_NO_USER_NEED;
        ctl_o.target = tlw_pkg::ST_MAP_ENT;
      end
      tlw_pkg::ST_MAP_SETU: begin
        ctl_o.mem_we   = 1'b1;
        ctl_o.addr_sel = tlw_pkg::A_DIR;
        ctl_o.wd_sel   = tlw_pkg::WD_DIRU;
      end
      tlw_pkg::ST_MAP_ENT: begin
        ctl_o.mem_we   = 1'b1;
        ctl_o.addr_sel = tlw_pkg::A_TAB;
        ctl_o.wd_sel   = tlw_pkg::WD_ENTRY;
        ctl_o.cond     = tlw_pkg::C_ALWAYS;
        ctl_o.target   = tlw_pkg::ST_DONE_WAIT;
      end
      tlw_pkg::ST_UN_CHK: begin
        ctl_o.cond   = tlw_pkg::C_DENT_ABSENT;
        ctl_o.target = tlw_pkg::ST_DONE_WAIT;
      end
      tlw_pkg::ST_UN_CLR: begin
        ctl_o.mem_we   = 1'b1;
        ctl_o.addr_sel = tlw_pkg::A_TAB;
        ctl_o.wd_sel   = tlw_pkg::WD_ZERO;
        ctl_o.cond     = tlw_pkg::C_ALWAYS;
        ctl_o.target   = tlw_pkg::ST_DONE_WAIT;
      end
      tlw_pkg::ST_XL_CHK: begin
        ctl_o.cond   = tlw_pkg::C_DENT_ABSENT;
        ctl_o.target = tlw_pkg::ST_DONE_WAIT;
      end
      tlw_pkg::ST_XL_RD: begin
        ctl_o.addr_sel = tlw_pkg::A_TAB;
      end
      tlw_pkg::ST_XL_RES: begin
        ctl_o.ld_result = 1'b1;
      end
      tlw_pkg::ST_DONE_WAIT: begin
        ctl_o.cond   = tlw_pkg::C_OUT_BUSY;
        ctl_o.target = tlw_pkg::ST_DONE_WAIT;
      end
      tlw_pkg::ST_DONE_OUT: begin
        ctl_o.out_load = 1'b1;
        ctl_o.cond     = tlw_pkg::C_ALWAYS;
        ctl_o.target   = tlw_pkg::ST_IDLE;
      end
      default: begin
        ctl_o.cond   = tlw_pkg::C_ALWAYS;
        ctl_o.target = tlw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/tlw_frame_mod.sv -----
`timescale 1ns / 1ps
// frame number reduction modulo TABLE_FRAMES, two register stages
// reciprocal multiply, back-multiply, then one compare and subtract
module tlw_frame_mod #(
  parameter int unsigned TABLE_FRAMES = 256
) (
  input  logic                              clk_i,
  input  logic [19:0]                       x_i,
  output logic [$clog2(TABLE_FRAMES)-1:0]   frame_o
);

  localparam int unsigned FrameW = $clog2(TABLE_FRAMES);
  localparam logic [31:0] MulK = 32'((64'd1 << 32) / TABLE_FRAMES);
  localparam logic [FrameW:0] NumW = (FrameW + 1)'(TABLE_FRAMES);
  localparam logic [19:0] NumX = 20'(TABLE_FRAMES);

  logic [51:0]     prod_q;
  logic [19:0]     x_q;
  logic [19:0]     quot;
  logic [19:0]     back;
  logic [19:0]     diff;
  logic [FrameW:0] r_q;
  logic [FrameW:0] r_sub;

  // quotient estimate is exact or one short, so the remainder stays below 2N
  always_ff @(posedge clk_i) begin
    prod_q <= {32'b0, x_i} * {20'b0, MulK};
    x_q    <= x_i;
    r_q    <= diff[FrameW:0];
  end

  always_comb begin
    quot    = prod_q[51:32];
    back    = quot * NumX;
    diff    = x_q - back;
    r_sub   = r_q - NumW;
    frame_o = (r_q >= NumW) ? r_sub[FrameW-1:0] : r_q[FrameW-1:0];
  end

endmodule

// ----- design/tlw_table_ram.sv -----
`timescale 1ns / 1ps
// single-port word store for directories and page tables, registered read
// no package dependency
module tlw_table_ram #(
  parameter int unsigned TABLE_FRAMES = 256
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [$clog2(TABLE_FRAMES)+9:0]      addr_i,
  input  logic [31:0]                          wdata_i,
  output logic [31:0]                          rdata_o
);

  localparam int unsigned Depth = TABLE_FRAMES * 1024;

  logic [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- design/two_level_page_table_walker_core.sv -----
`timescale 1ns / 1ps
// each item is one microcode walk through the single-port table memory, longer when map builds a table
// a new input item is taken only after the walk of the previous one has loaded its result
// the next item is taken while an earlier result still waits in the output register
// reset: async, active low; afterwards a clearing pass writes zero to all
// TABLE_FRAMES*1024 words, no input beat taken until it ends
module two_level_page_table_walker_core #(
  parameter int unsigned TABLE_FRAMES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tlw_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tlw_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlw_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned FrameW = $clog2(TABLE_FRAMES);
  localparam int unsigned AddrW  = FrameW + tlw_pkg::EntryIdxW;
  localparam int unsigned Depth  = TABLE_FRAMES * 1024;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  tlw_pkg::ctl_t  ctl;
  tlw_pkg::step_t pc_q, pc_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [7:0]       dir_q;
  logic             out_valid_q;
  logic             jump;

  tlw_pkg::in_item_t  item_q;
  tlw_pkg::out_item_t out_q;
  logic [FrameW-1:0]  dfr_q, nf_q, tf_q;
  logic [31:0]        dent_q;
  logic [31:0]        res_q;
  logic               mapped_q;
  logic               created_q;

  logic [19:0]        mod_x;
  logic [FrameW-1:0]  mod_frame;
  logic [AddrW-1:0]   mem_addr;
  logic [31:0]        mem_wdata;
  logic [31:0]        mem_rdata;

  logic in_fire, out_fire, cfg_wr;

  tlw_ucode_rom u_rom (
    .step_i (pc_q),
    .ctl_o  (ctl)
  );

  tlw_frame_mod #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_mod (
    .clk_i   (clk_i),
    .x_i     (mod_x),
    .frame_o (mod_frame)
  );

  tlw_table_ram #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl.mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o  = ctl.in_ready;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == tlw_pkg::RegDirectoryFrame[2]);
  assign prdata = (paddr[2] == tlw_pkg::RegDirectoryFrame[2]) ? {24'b0, dir_q} : 32'b0;

  // branch condition
  always_comb begin
    unique case (ctl.cond)
      tlw_pkg::C_NEVER:        jump = 1'b0;
      tlw_pkg::C_ALWAYS:       jump = 1'b1;
      tlw_pkg::C_NO_ACCEPT:    jump = !in_valid_i;
      tlw_pkg::C_CNT_MORE:     jump = (cnt_q != LastAddr);
      tlw_pkg::C_TBL_MORE:     jump = (cnt_q[tlw_pkg::EntryIdxW-1:0] != '1);
      tlw_pkg::C_IS_MAP:       jump = (item_q.action == tlw_pkg::ACT_MAP);
      tlw_pkg::C_IS_UNMAP:     jump = (item_q.action == tlw_pkg::ACT_UNMAP);
      tlw_pkg::C_IS_XLATE:     jump = (item_q.action == tlw_pkg::ACT_XLATE);
      tlw_pkg::C_DENT_PRESENT: jump = dent_q[tlw_pkg::EntPresent];
      tlw_pkg::C_DENT_ABSENT:  jump = !dent_q[tlw_pkg::EntPresent];
      tlw_pkg::C_NO_USER_NEED: jump = !(item_q.page_flags[tlw_pkg::EntUser] &&
                                        !dent_q[tlw_pkg::EntUser]);
      tlw_pkg::C_OUT_BUSY:     jump = out_valid_q && !out_ready_i;
      default:                 jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = jump ? ctl.target : pc_q + 1'b1;
    unique case (ctl.cnt_op)
      tlw_pkg::CNT_CLR: cnt_d = '0;
      tlw_pkg::CNT_INC: cnt_d = cnt_q + 1'b1;
      default:          cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    unique case (ctl.mod_src)
      tlw_pkg::MS_CFG:   mod_x = 20'(dir_q);
      tlw_pkg::MS_SPARE: mod_x = 20'(item_q.spare_table_frame);
      tlw_pkg::MS_RDATA: mod_x = mem_rdata[31:12];
      default:           mod_x = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.addr_sel)
      tlw_pkg::A_ALL:    mem_addr = cnt_q;
      tlw_pkg::A_TBLCLR: mem_addr = {nf_q, cnt_q[tlw_pkg::EntryIdxW-1:0]};
      tlw_pkg::A_DIR:    mem_addr = {dfr_q, item_q.virtual_address[31:22]};
      tlw_pkg::A_TAB:    mem_addr = {tf_q, item_q.virtual_address[21:12]};
      default:           mem_addr = cnt_q;
    endcase
  end

  always_comb begin
    unique case (ctl.wd_sel)
      tlw_pkg::WD_ZERO:   mem_wdata = 32'b0;
      // new directory entry: present, writable, user on request
      tlw_pkg::WD_NEWDIR: mem_wdata = {20'(nf_q), 9'b0,
                                       item_q.page_flags[tlw_pkg::EntUser], 2'b11};
      tlw_pkg::WD_DIRU:   mem_wdata = dent_q | 32'h0000_0004;
      tlw_pkg::WD_ENTRY:  mem_wdata = {item_q.physical_address[31:12],
                                       item_q.page_flags | 12'h001};
      default:            mem_wdata = 32'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= tlw_pkg::ST_CLRALL;
      cnt_q       <= '0;
      dir_q       <= 8'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
      if (cfg_wr) begin
        dir_q <= pwdata[7:0];
      end
      if (ctl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    if (ctl.ld_dirf) begin
      dfr_q <= mod_frame;
    end
    if (ctl.ld_nf) begin
      nf_q <= mod_frame;
    end
    if (ctl.ld_dent) begin
      dent_q <= mem_rdata;
    end
    unique case (ctl.tf_sel)
      tlw_pkg::TF_MOD: tf_q <= mod_frame;
      tlw_pkg::TF_NF:  tf_q <= nf_q;
      default:         tf_q <= tf_q;
    endcase
    if (ctl.clr_res) begin
      res_q     <= 32'b0;
      mapped_q  <= 1'b0;
      created_q <= 1'b0;
    end else begin
      if (ctl.ld_created) begin
        created_q <= 1'b1;
      end
      if (ctl.ld_result && mem_rdata[tlw_pkg::EntPresent]) begin
        res_q    <= {mem_rdata[31:12], item_q.virtual_address[11:0]};
        mapped_q <= 1'b1;
      end
    end
    if (ctl.out_load) begin
      out_q.physical_result <= res_q;
      out_q.mapped          <= mapped_q;
      out_q.table_created   <= created_q;
    end
  end

endmodule

// ----- design/tlw_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the page table walker core, bound to two_level_page_table_walker_core
// depends on tlw_pkg and two_level_page_table_walker_core
module tlw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tlw_pkg::out_item_t out_data_o
);

  // one item at a time: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat dropped or changed");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.mapped |-> out_data_o.physical_result == 32'b0)
    else $error("physical result nonzero without a mapping");

  // only map creates tables and only translate reports a mapping
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.mapped && out_data_o.table_created))
    else $error("mapped and table_created both set");

endmodule

bind two_level_page_table_walker_core tlw_checker u_tlw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
